/* rtl/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, fixed-point constants and the cordic angle table for the
// schwarzschild connection coefficient block.
// ----------------------------------------------------------------------------
package scs_pkg;

    // cordic datapath widths: x/y in q1.30 with headroom, z in q32 radians
    localparam int XW = 34;
    localparam int ZW = 36;

    // angle constants in q3.28
    localparam logic signed [33:0] Q28_PI       = 34'sd843314857;
    localparam logic signed [33:0] Q28_NEG_PI   = -34'sd843314857;
    localparam logic signed [33:0] Q28_HALF     = 34'sd421657428;
    localparam logic signed [33:0] Q28_NEG_HALF = -34'sd421657428;
    localparam logic signed [33:0] Q28_TWO_PI   = 34'sd1686629713;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [XW-1:0] NEG_ONE_Q30 = -34'sd1073741824;
    localparam logic signed [31:0]   EPS_Q30     = 32'sd11;

    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [31:0] RS_RESET = 32'd131072;

    // divider geometry
    localparam int NUM_W = 128;
    localparam int DEN_W = 96;
    localparam int QUO_W = 64;

    // coordinate index codes
    localparam logic [1:0] IDX_T  = 2'd0;
    localparam logic [1:0] IDX_R  = 2'd1;
    localparam logic [1:0] IDX_TH = 2'd2;
    localparam logic [1:0] IDX_PH = 2'd3;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_DIV_ZERO
    } status_t;

    typedef enum logic [3:0] {
        OP_ZERO,
        OP_T_TR,
        OP_R_RR,
        OP_R_TT,
        OP_R_THTH,
        OP_R_PHPH,
        OP_INV_R,
        OP_TH_PHPH,
        OP_COT
    } op_t;

    // classified request as it leaves the front end
    typedef struct packed {
        op_t                   op;
        logic [31:0]           radius;
        logic [31:0]           rs;
        logic [31:0]           diff;
        logic                  r_gt_s;
        logic                  r_lt_s;
        logic                  r_zero;
        logic                  diff_zero;
        logic                  flip;
        logic signed [ZW-1:0]  angle;
    } item_t;

    function automatic logic signed [ZW-1:0] atan_q32(input int unsigned i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 36'sd3373259426;
            1:  v = 36'sd1991351318;
            2:  v = 36'sd1052175346;
            3:  v = 36'sd534100635;
            4:  v = 36'sd268086748;
            5:  v = 36'sd134174063;
            6:  v = 36'sd67103403;
            7:  v = 36'sd33553749;
            8:  v = 36'sd16777131;
            9:  v = 36'sd8388597;
            10: v = 36'sd4194303;
            default:
            begin
                if (i <= 32)
                begin
                    v = ZW'(64'd1 << (32 - i));
                end
                else
                begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

/* rtl/scs_channels.sv */
// ----------------------------------------------------------------------------
// scs channels
// Valid/ready request and response channels of the coefficient block.
// ----------------------------------------------------------------------------
interface scs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         upper_index;
    logic [1:0]         lower_index_a;
    logic [1:0]         lower_index_b;
    logic [31:0]        radius;
    logic signed [31:0] polar_angle;

    modport source (
        output valid, upper_index, lower_index_a, lower_index_b, radius, polar_angle,
        input  ready
    );
    modport sink (
        input  valid, upper_index, lower_index_a, lower_index_b, radius, polar_angle,
        output ready
    );
endinterface

interface scs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] coefficient;
    logic [1:0]         status;

    modport source (
        output valid, coefficient, status,
        input  ready
    );
    modport sink (
        input  valid, coefficient, status,
        output ready
    );
endinterface

/* rtl/schwarzschild_christoffel_symbol.sv */
// throughput: one transaction per cycle while the response side accepts, set by the
// fully pipelined cordic and the 64-stage radix-2 divider; a stalled response
// freezes the cordic and the back end
// reset: asynchronous active low, clears all valid state and loads rs = 2.0
// ----------------------------------------------------------------------------
// schwarzschild_christoffel_symbol
// Connection coefficients of the vacuum schwarzschild metric, one request in
// and one response out per transaction.
// ----------------------------------------------------------------------------
module schwarzschild_christoffel_symbol #(
    parameter int CORDIC_STEPS = 28
) (
    input  logic        clk,
    input  logic        rst_n,
    scs_req_if.sink     req,
    scs_rsp_if.source   rsp,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data
);
    import scs_pkg::*;

    logic [31:0]          horizon_radius_reg;
    logic [31:0]          horizon_radius_next;
    item_t                f_item;
    logic                 f_valid;
    logic                 f_ready;
    item_t                q_item;
    logic                 q_valid;
    logic                 adv;
    item_t                c_item;
    logic                 c_valid;
    logic signed [XW-1:0] c_x;
    logic signed [XW-1:0] c_y;

    assign horizon_radius_next = cfg_write_en ? cfg_write_data : horizon_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_radius_reg <= RS_RESET;
        end
        else
        begin
            horizon_radius_reg <= horizon_radius_next;
        end
    end

    scs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rs         (horizon_radius_reg),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    scs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_item  (f_item),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop_ready  (adv)
    );

    scs_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .out_valid (c_valid),
        .out_item  (c_item),
        .out_x     (c_x),
        .out_y     (c_y)
    );

    scs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_valid),
        .in_item  (c_item),
        .in_x     (c_x),
        .in_y     (c_y),
        .adv      (adv),
        .rsp      (rsp)
    );

endmodule

/* rtl/scs_front.sv */
// ----------------------------------------------------------------------------
// scs_front
// Accepts requests, orders the lower indices, classifies the coefficient and
// reduces the polar angle into the cordic range.
// ----------------------------------------------------------------------------
module scs_front (
    input  logic            clk,
    input  logic            rst_n,
    scs_req_if.sink         req,
    input  logic [31:0]     rs,
    output scs_pkg::item_t  item,
    output logic            item_valid,
    input  logic            item_ready
);
    import scs_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    item_t             item_reg;
    item_t             item_next;
    logic              accept;
    logic [1:0]        lo;
    logic [1:0]        hi;
    op_t               op;
    logic signed [33:0] a0;
    logic signed [33:0] a1;
    logic signed [33:0] a2;
    logic signed [33:0] a3;
    logic              flip;

    assign req.ready  = !valid_reg || item_ready;
    assign accept     = req.valid && req.ready;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    // symmetric in the lower pair
    always_comb
    begin
        if (req.lower_index_a > req.lower_index_b)
        begin
            lo = req.lower_index_b;
            hi = req.lower_index_a;
        end
        else
        begin
            lo = req.lower_index_a;
            hi = req.lower_index_b;
        end
    end

    always_comb
    begin
        unique case ({req.upper_index, lo, hi}) inside
            {IDX_T, IDX_T, IDX_R}:                        op = OP_T_TR;
            {IDX_R, IDX_R, IDX_R}:                        op = OP_R_RR;
            {IDX_R, IDX_T, IDX_T}:                        op = OP_R_TT;
            {IDX_R, IDX_TH, IDX_TH}:                      op = OP_R_THTH;
            {IDX_R, IDX_PH, IDX_PH}:                      op = OP_R_PHPH;
            {IDX_TH, IDX_R, IDX_TH}, {IDX_PH, IDX_R, IDX_PH}: op = OP_INV_R;
            {IDX_TH, IDX_PH, IDX_PH}:                     op = OP_TH_PHPH;
            {IDX_PH, IDX_TH, IDX_PH}:                     op = OP_COT;
            default:                                      op = OP_ZERO;
        endcase
    end

    // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb
    begin
        a0 = {{2{req.polar_angle[31]}}, req.polar_angle};
        a1 = (a0 > Q28_PI) ? a0 - Q28_TWO_PI : a0;
        a2 = (a1 < Q28_NEG_PI) ? a1 + Q28_TWO_PI : a1;
        if (a2 > Q28_HALF)
        begin
            a3   = Q28_PI - a2;
            flip = 1'b1;
        end
        else if (a2 < Q28_NEG_HALF)
        begin
            a3   = Q28_NEG_PI - a2;
            flip = 1'b1;
        end
        else
        begin
            a3   = a2;
            flip = 1'b0;
        end
    end

    always_comb
    begin
        item_next = item_reg;
        if (accept)
        begin
            item_next.op        = op;
            item_next.radius    = req.radius;
            item_next.rs        = rs;
            item_next.diff      = (req.radius >= rs) ? req.radius - rs : rs - req.radius;
            item_next.r_gt_s    = req.radius > rs;
            item_next.r_lt_s    = req.radius < rs;
            item_next.r_zero    = req.radius == 32'd0;
            item_next.diff_zero = req.radius == rs;
            item_next.flip      = flip;
            item_next.angle     = ZW'(a3) <<< 4;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

/* rtl/scs_queue.sv */
// ----------------------------------------------------------------------------
// scs_queue
// Two-entry queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module scs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  scs_pkg::item_t  push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output scs_pkg::item_t  pop_item,
    input  logic            pop_ready
);
    import scs_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/scs_cordic.sv */
// ----------------------------------------------------------------------------
// scs_cordic
// Pipelined rotation cordic, one micro-rotation per stage, carrying the
// classified request alongside.
// ----------------------------------------------------------------------------
module scs_cordic #(
    parameter int STEPS = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  scs_pkg::item_t                in_item,
    output logic                          out_valid,
    output scs_pkg::item_t                out_item,
    output logic signed [scs_pkg::XW-1:0] out_x,
    output logic signed [scs_pkg::XW-1:0] out_y
);
    import scs_pkg::*;

    logic                 valid_reg [STEPS];
    item_t                item_reg  [STEPS];
    logic signed [XW-1:0] x_reg     [STEPS];
    logic signed [XW-1:0] y_reg     [STEPS];
    logic signed [ZW-1:0] z_reg     [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        item_t                it_in;
        logic                 v_in;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (i == 0)
        begin : g_first
            assign x_in  = CORDIC_GAIN;
            assign y_in  = '0;
            assign z_in  = in_item.angle;
            assign it_in = in_item;
            assign v_in  = in_valid;
        end
        else
        begin : g_rest
            assign x_in  = x_reg[i-1];
            assign y_in  = y_reg[i-1];
            assign z_in  = z_reg[i-1];
            assign it_in = item_reg[i-1];
            assign v_in  = valid_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = atan_q32(i);

        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - at;
            end
            else
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                item_reg[i] <= it_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_item  = item_reg[STEPS-1];
    assign out_x     = x_reg[STEPS-1];
    assign out_y     = y_reg[STEPS-1];

endmodule

/* rtl/scs_back.sv */
// ----------------------------------------------------------------------------
// scs_back
// Trig post-processing, products, per-case selection, a radix-2 pipelined
// divider with overflow detection, and the response register.
// ----------------------------------------------------------------------------
module scs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  scs_pkg::item_t                in_item,
    input  logic signed [scs_pkg::XW-1:0] in_x,
    input  logic signed [scs_pkg::XW-1:0] in_y,
    output logic                          adv,
    scs_rsp_if.source                     rsp
);
    import scs_pkg::*;

    typedef struct packed {
        item_t       item;
        logic [30:0] sm;
        logic [30:0] cm;
        logic [30:0] dm;
        logic        s_neg;
        logic        c_neg;
        logic        den_neg;
        logic        den_zero;
    } trig_t;

    typedef struct packed {
        trig_t       trig;
        logic [61:0] sq;
        logic [61:0] sc;
        logic [63:0] rd;
        logic [63:0] sd;
        logic [63:0] r2;
    } prod_t;

    typedef struct packed {
        trig_t       trig;
        logic [61:0] sc;
        logic [62:0] pd;
        logic [63:0] rd;
        logic [63:0] sd;
        logic [63:0] ph;
        logic [63:0] pl;
    } wide_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [63:0]      nlo;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] denom;
        logic             ovf;
        logic             neg;
        logic             use_div;
        logic [63:0]      coef;
        status_t          status;
    } div_t;

    // stage registers
    logic    t_valid_reg;
    trig_t   t_reg;
    trig_t   t_next;
    logic    p_valid_reg;
    prod_t   p_reg;
    prod_t   p_next;
    logic    w_valid_reg;
    wide_t   w_reg;
    wide_t   w_next;
    logic    d_valid_reg [QUO_W+1];
    div_t    d_reg       [QUO_W+1];
    div_t    d0_next;
    logic    out_valid_reg;
    logic [63:0] coef_reg;
    logic [63:0] coef_next;
    status_t status_reg;
    status_t status_next;

    // trig post-processing
    logic signed [XW-1:0] xc;
    logic signed [XW-1:0] yc;
    logic signed [31:0]   s;
    logic signed [31:0]   c;
    logic signed [31:0]   den;
    logic [31:0]          s_abs;
    logic [31:0]          c_abs;
    logic [31:0]          d_abs;

    // case selection
    logic [95:0]  r3;
    logic [32:0]  ds;
    logic [63:0]  m;
    logic [NUM_W-1:0] numer;
    div_t         dl;
    logic [63:0]  limit;

    assign adv = !out_valid_reg || rsp.ready;

    always_comb
    begin
        xc = (in_x > ONE_Q30) ? ONE_Q30 : ((in_x < NEG_ONE_Q30) ? NEG_ONE_Q30 : in_x);
        yc = (in_y > ONE_Q30) ? ONE_Q30 : ((in_y < NEG_ONE_Q30) ? NEG_ONE_Q30 : in_y);
        s  = 32'(yc);
        c  = in_item.flip ? -32'(xc) : 32'(xc);
        den   = s + EPS_Q30;
        s_abs = s[31] ? 32'(-s) : 32'(s);
        c_abs = c[31] ? 32'(-c) : 32'(c);
        d_abs = den[31] ? 32'(-den) : 32'(den);
        t_next.item     = in_item;
        t_next.sm       = s_abs[30:0];
        t_next.cm       = c_abs[30:0];
        t_next.dm       = d_abs[30:0];
        t_next.s_neg    = s[31];
        t_next.c_neg    = c[31];
        t_next.den_neg  = den[31];
        t_next.den_zero = den == 32'sd0;
    end

    always_comb
    begin
        p_next.trig = t_reg;
        p_next.sq   = 62'(t_reg.sm) * 62'(t_reg.sm);
        p_next.sc   = 62'(t_reg.sm) * 62'(t_reg.cm);
        p_next.rd   = 64'(t_reg.item.radius) * 64'(t_reg.item.diff);
        p_next.sd   = 64'(t_reg.item.rs) * 64'(t_reg.item.diff);
        p_next.r2   = 64'(t_reg.item.radius) * 64'(t_reg.item.radius);
    end

    // r^3 as two 32x32 partial products, summed in the next stage
    always_comb
    begin
        w_next.trig = p_reg.trig;
        w_next.sc   = p_reg.sc;
        w_next.rd   = p_reg.rd;
        w_next.sd   = p_reg.sd;
        w_next.pd   = 63'(p_reg.trig.item.diff) * 63'(p_reg.sq[61:30]);
        w_next.ph   = 64'(p_reg.r2[63:32]) * 64'(p_reg.trig.item.radius);
        w_next.pl   = 64'(p_reg.r2[31:0]) * 64'(p_reg.trig.item.radius);
    end

    always_comb
    begin
        r3      = {w_reg.ph, 32'd0} + 96'(w_reg.pl);
        ds      = {1'b0, w_reg.trig.item.rs} - {1'b0, w_reg.trig.item.radius};
        m       = '0;
        numer   = '0;
        d0_next = '0;
        d0_next.denom  = 96'd1;
        d0_next.status = ST_OK;
        unique case (w_reg.trig.item.op) inside
            OP_T_TR, OP_R_RR:
            begin
                if (w_reg.trig.item.r_zero || w_reg.trig.item.diff_zero)
                begin
                    d0_next.coef   = (w_reg.trig.item.op == OP_R_RR) ? NEG_MIN : POS_MAX;
                    d0_next.status = ST_DIV_ZERO;
                end
                else
                begin
                    numer           = NUM_W'(w_reg.trig.item.rs) << 47;
                    d0_next.denom   = DEN_W'(w_reg.rd);
                    d0_next.use_div = 1'b1;
                    d0_next.neg     = (w_reg.trig.item.op == OP_R_RR) ?
                                      w_reg.trig.item.r_gt_s : w_reg.trig.item.r_lt_s;
                end
            end
            OP_R_TT:
            begin
                if (w_reg.trig.item.r_zero)
                begin
                    d0_next.coef   = (w_reg.trig.item.rs != 32'd0) ? NEG_MIN : POS_MAX;
                    d0_next.status = ST_DIV_ZERO;
                end
                else
                begin
                    numer           = NUM_W'(w_reg.sd) << 47;
                    d0_next.denom   = r3;
                    d0_next.use_div = 1'b1;
                    d0_next.neg     = w_reg.trig.item.r_lt_s;
                end
            end
            OP_R_THTH:
            begin
                d0_next.coef = {{15{ds[32]}}, ds, 16'd0};
            end
            OP_R_PHPH:
            begin
                m            = 64'(w_reg.pd >> 14);
                d0_next.coef = w_reg.trig.item.r_gt_s ? -m : m;
            end
            OP_INV_R:
            begin
                if (w_reg.trig.item.r_zero)
                begin
                    d0_next.coef   = POS_MAX;
                    d0_next.status = ST_DIV_ZERO;
                end
                else
                begin
                    numer           = NUM_W'(1) << 48;
                    d0_next.denom   = DEN_W'(w_reg.trig.item.radius);
                    d0_next.use_div = 1'b1;
                end
            end
            OP_TH_PHPH:
            begin
                m            = 64'(w_reg.sc >> 28);
                d0_next.coef = (w_reg.trig.s_neg == w_reg.trig.c_neg) ? -m : m;
            end
            OP_COT:
            begin
                if (w_reg.trig.den_zero)
                begin
                    d0_next.coef   = w_reg.trig.c_neg ? NEG_MIN : POS_MAX;
                    d0_next.status = ST_DIV_ZERO;
                end
                else
                begin
                    numer           = NUM_W'(w_reg.trig.cm) << 32;
                    d0_next.denom   = DEN_W'(w_reg.trig.dm);
                    d0_next.use_div = 1'b1;
                    d0_next.neg     = w_reg.trig.c_neg ^ w_reg.trig.den_neg;
                end
            end
            default:
            begin
                d0_next.coef = '0;
            end
        endcase
        // upper half seeds the remainder, lower half is shifted in bit by bit
        d0_next.rem = DEN_W'(numer[NUM_W-1:QUO_W]);
        d0_next.nlo = numer[QUO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
            w_valid_reg    <= 1'b0;
            d_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg    <= in_valid;
            p_valid_reg    <= t_valid_reg;
            w_valid_reg    <= p_valid_reg;
            d_valid_reg[0] <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= t_next;
            p_reg    <= p_next;
            w_reg    <= w_next;
            d_reg[0] <= d0_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic [DEN_W:0] trial;
        logic           ge;
        div_t           step_next;

        always_comb
        begin
            trial     = {d_reg[j].rem, d_reg[j].nlo[QUO_W-1]};
            ge        = trial >= {1'b0, d_reg[j].denom};
            step_next = d_reg[j];
            step_next.rem = ge ? DEN_W'(trial - {1'b0, d_reg[j].denom}) : trial[DEN_W-1:0];
            step_next.quo = {d_reg[j].quo[QUO_W-2:0], ge};
            step_next.nlo = d_reg[j].nlo << 1;
            if (j == 0)
            begin
                // quotient needs more than 64 bits
                step_next.ovf = d_reg[j].rem >= d_reg[j].denom;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                d_valid_reg[j+1] <= d_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[j+1] <= step_next;
            end
        end
    end

    always_comb
    begin
        dl    = d_reg[QUO_W];
        limit = dl.neg ? NEG_MIN : POS_MAX;
        if (dl.use_div)
        begin
            if (dl.ovf || dl.quo > limit)
            begin
                coef_next   = dl.neg ? NEG_MIN : POS_MAX;
                status_next = ST_OVERFLOW;
            end
            else
            begin
                coef_next   = dl.neg ? -dl.quo : dl.quo;
                status_next = ST_OK;
            end
        end
        else
        begin
            coef_next   = dl.coef;
            status_next = dl.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coef_reg   <= coef_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.coefficient = coef_reg;
    assign rsp.status      = status_reg;

endmodule

/* rtl/scs_checker.sv */
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] coefficient,
    input logic [1:0]  status
);
    import scs_pkg::*;

    // no response while reset is held
    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // a stalled transaction keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(coefficient) && $stable(status))
        else $error("stalled response changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == ST_OK || status == ST_OVERFLOW || status == ST_DIV_ZERO)
        else $error("undefined status code");

    // any error status comes with a saturated coefficient
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> coefficient == POS_MAX || coefficient == NEG_MIN)
        else $error("error status without saturation");

endmodule

bind schwarzschild_christoffel_symbol scs_checker u_scs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .coefficient (rsp.coefficient),
    .status      (rsp.status)
);
